/* hw/rtl/rmtp_pkg.sv */
// ----------------------------------------------------------------------------
// rmtp_pkg
// Shared widths, constants and types for the rate monotonic task picker.
// ----------------------------------------------------------------------------
package rmtp_pkg;

   localparam int TASK_CNT = 4;
   localparam int IDX_W    = 2;
   localparam int CNT_W    = 10;
   localparam int CSR_IDX_W = 4;

   localparam logic [CNT_W-1:0] IDLE_PERIOD  = 10'd1000;
   localparam logic [CNT_W-1:0] PERIOD_RESET = 10'd1;

   localparam logic [1:0] CSR_GRP_PERIOD = 2'd0;
   localparam logic [1:0] CSR_GRP_BUDGET = 2'd1;

   typedef struct packed {
      logic             go;
      logic             found;
      logic [IDX_W-1:0] idx;
      logic [CNT_W-1:0] period;
      logic [CNT_W-1:0] left;
   } token_type;

   typedef struct packed {
      logic tick;
      logic ready;
      logic dec;
      logic wr_period;
      logic wr_budget;
   } cell_ctl_type;

endpackage

/* hw/rtl/rate_monotonic_task_picker_unit.sv */
// ----------------------------------------------------------------------------
// rate_monotonic_task_picker_unit
// Rate monotonic task picker for four tasks built as a chain of task cells.
// ----------------------------------------------------------------------------
// usage:
//   request: start with req_ready_mask, taken when start is high and busy low
//   result: rsp_strobe high for one cycle with rsp_run_idle and rsp_task_index
//   csr: csr_valid/csr_ready with csr_index and csr_data; csr_ready is always
//     high; index 0..3 are task periods, 4..7 budgets, others are dropped
//   empty ready mask: result strobes the cycle after the request, busy stays low
//   otherwise counters reload and step at the request edge, then a candidate
//   token walks the four cells, one cell per cycle; the result passes the
//   seed register, the four cell registers and the output register that
//   retires the winner, and busy drops in the cycle the result strobes
//   reset: periods go to one, budgets and counters to zero, busy low
//   the receiver cannot stall; each result is shown for exactly one cycle
// ----------------------------------------------------------------------------
module rate_monotonic_task_picker_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [rmtp_pkg::TASK_CNT-1:0]  req_ready_mask,
   output logic                           rsp_strobe,
   output logic                           rsp_run_idle,
   output logic [rmtp_pkg::IDX_W-1:0]     rsp_task_index,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rmtp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rmtp_pkg::CNT_W-1:0]     csr_data
);

   logic                       busy_ff, busy_in;
   logic                       seed_ff, seed_in;
   logic                       strobe_ff, strobe_in;
   logic                       run_idle_ff, run_idle_in;
   logic [rmtp_pkg::IDX_W-1:0] task_index_ff, task_index_in;

   logic accept;
   logic live;
   logic csr_wr;

   rmtp_pkg::token_type    tok [rmtp_pkg::TASK_CNT+1];
   rmtp_pkg::cell_ctl_type ctl [rmtp_pkg::TASK_CNT];

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   assign accept    = start && !busy_ff;
   assign live      = |req_ready_mask;

   always_comb begin
      tok[0].go     = seed_ff;
      tok[0].found  = 1'b0;
      tok[0].idx    = '0;
      tok[0].period = '0;
      tok[0].left   = '0;
   end

   genvar g;
   generate
      for (g = 0; g < rmtp_pkg::TASK_CNT; g++) begin : g_cell
         always_comb begin
            ctl[g].tick      = accept && live;
            ctl[g].ready     = req_ready_mask[g];
            ctl[g].dec       = tok[rmtp_pkg::TASK_CNT].go &&
                               tok[rmtp_pkg::TASK_CNT].found &&
                               (tok[rmtp_pkg::TASK_CNT].idx ==
                                rmtp_pkg::IDX_W'(g));
            ctl[g].wr_period = csr_wr &&
                               (csr_index[3:2] == rmtp_pkg::CSR_GRP_PERIOD) &&
                               (csr_index[1:0] == rmtp_pkg::IDX_W'(g));
            ctl[g].wr_budget = csr_wr &&
                               (csr_index[3:2] == rmtp_pkg::CSR_GRP_BUDGET) &&
                               (csr_index[1:0] == rmtp_pkg::IDX_W'(g));
         end

         rmtp_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .cell_idx (rmtp_pkg::IDX_W'(g)),
            .ctl      (ctl[g]),
            .csr_data (csr_data),
            .tok_in   (tok[g]),
            .tok_out  (tok[g+1])
         );
      end
   endgenerate

   always_comb begin
      busy_in       = busy_ff;
      seed_in       = 1'b0;
      strobe_in     = 1'b0;
      run_idle_in   = run_idle_ff;
      task_index_in = task_index_ff;
      if (accept) begin
         if (live) begin
            busy_in = 1'b1;
            seed_in = 1'b1;
         end else begin
            strobe_in     = 1'b1;
            run_idle_in   = 1'b1;
            task_index_in = '0;
         end
      end else if (tok[rmtp_pkg::TASK_CNT].go) begin
         busy_in       = 1'b0;
         strobe_in     = 1'b1;
         run_idle_in   = !tok[rmtp_pkg::TASK_CNT].found;
         task_index_in = tok[rmtp_pkg::TASK_CNT].found ?
                         tok[rmtp_pkg::TASK_CNT].idx : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         seed_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         seed_ff   <= seed_in;
         strobe_ff <= strobe_in;
      end
      run_idle_ff   <= run_idle_in;
      task_index_ff <= task_index_in;
   end

   assign busy           = busy_ff;
   assign rsp_strobe     = strobe_ff;
   assign rsp_run_idle   = run_idle_ff;
   assign rsp_task_index = task_index_ff;

endmodule

/* hw/rtl/rmtp_cell.sv */
// ----------------------------------------------------------------------------
// rmtp_cell
// One task slot: holds its period and budget settings and counters, and
// updates the best-candidate token passed along the chain.
// ----------------------------------------------------------------------------
module rmtp_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [rmtp_pkg::IDX_W-1:0] cell_idx,
   input  rmtp_pkg::cell_ctl_type     ctl,
   input  logic [rmtp_pkg::CNT_W-1:0] csr_data,
   input  rmtp_pkg::token_type        tok_in,
   output rmtp_pkg::token_type        tok_out
);

   logic [rmtp_pkg::CNT_W-1:0] period_cfg_ff, period_cfg_in;
   logic [rmtp_pkg::CNT_W-1:0] budget_cfg_ff, budget_cfg_in;
   logic [rmtp_pkg::CNT_W-1:0] period_left_ff, period_left_in;
   logic [rmtp_pkg::CNT_W-1:0] budget_left_ff, budget_left_in;
   logic                       ready_ff, ready_in;
   rmtp_pkg::token_type        tok_ff, tok_step_in;

   logic [rmtp_pkg::CNT_W-1:0] pl_reload;
   logic                       eligible;
   logic                       take;

   always_comb begin
      period_cfg_in  = ctl.wr_period ? csr_data : period_cfg_ff;
      budget_cfg_in  = ctl.wr_budget ? csr_data : budget_cfg_ff;
      ready_in       = ctl.tick ? ctl.ready : ready_ff;
      period_left_in = period_left_ff;
      budget_left_in = budget_left_ff;
      pl_reload      = (period_left_ff == '0) ? period_cfg_ff : period_left_ff;
      if (ctl.tick) begin
         if (period_left_ff == '0) begin
            budget_left_in = budget_cfg_ff;
         end
         period_left_in = (pl_reload != '0) ? pl_reload - rmtp_pkg::CNT_W'(1) : '0;
      end else if (ctl.dec) begin
         budget_left_in = budget_left_ff - rmtp_pkg::CNT_W'(1);
      end

      // compare against best so far
      eligible = ready_ff && (budget_left_ff != '0) &&
                 (period_cfg_ff < rmtp_pkg::IDLE_PERIOD);
      take = eligible && (!tok_in.found || (period_cfg_ff < tok_in.period) ||
             ((period_cfg_ff == tok_in.period) && (period_left_ff < tok_in.left)));
      tok_step_in = tok_in;
      if (take) begin
         tok_step_in.found  = 1'b1;
         tok_step_in.idx    = cell_idx;
         tok_step_in.period = period_cfg_ff;
         tok_step_in.left   = period_left_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_cfg_ff  <= rmtp_pkg::PERIOD_RESET;
         budget_cfg_ff  <= '0;
         period_left_ff <= '0;
         budget_left_ff <= '0;
         ready_ff       <= 1'b0;
         tok_ff.go      <= 1'b0;
      end else begin
         period_cfg_ff  <= period_cfg_in;
         budget_cfg_ff  <= budget_cfg_in;
         period_left_ff <= period_left_in;
         budget_left_ff <= budget_left_in;
         ready_ff       <= ready_in;
         tok_ff.go      <= tok_step_in.go;
      end
      tok_ff.found  <= tok_step_in.found;
      tok_ff.idx    <= tok_step_in.idx;
      tok_ff.period <= tok_step_in.period;
      tok_ff.left   <= tok_step_in.left;
   end

   assign tok_out = tok_ff;

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the rate monotonic task picker unit.
// Runs scheduler ticks in phases under changing task periods and budgets,
// predicts every pick inside the bench and checks each result strobe in order.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CSR_PERIOD_BASE  = 0;
   localparam int CSR_BUDGET_BASE  = 4;
   localparam int CSR_SPARE_FIRST  = 8;
   localparam int CSR_SPARE_LAST   = 15;
   localparam int MASK_MAX         = (1 << rmtp_pkg::TASK_CNT) - 1;
   localparam int SHOWN_MISMATCHES = 10;
   localparam int STALL_LIMIT      = 2000;
   localparam int DRAIN_CYCLES     = 8;
   localparam int RAND_PHASES      = 8;
   localparam int PHASE_TICKS      = 190;

   typedef struct packed {
      logic                       run_idle;
      logic [rmtp_pkg::IDX_W-1:0] task_index;
   } pick_type;

   logic                           clock;
   logic                           reset = 1'b1;
   logic                           start = 1'b0;
   logic                           busy;
   logic [rmtp_pkg::TASK_CNT-1:0]  req_ready_mask = '0;
   logic                           rsp_strobe;
   logic                           rsp_run_idle;
   logic [rmtp_pkg::IDX_W-1:0]     rsp_task_index;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [rmtp_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [rmtp_pkg::CNT_W-1:0]     csr_data = '0;

   logic [rmtp_pkg::TASK_CNT-1:0]  pending_ticks[$];
   pick_type                       expected_picks[$];
   logic [rmtp_pkg::CNT_W-1:0]     period_cfg[rmtp_pkg::TASK_CNT];
   logic [rmtp_pkg::CNT_W-1:0]     budget_cfg[rmtp_pkg::TASK_CNT];
   logic [rmtp_pkg::CNT_W-1:0]     period_left[rmtp_pkg::TASK_CNT];
   logic [rmtp_pkg::CNT_W-1:0]     budget_left[rmtp_pkg::TASK_CNT];
   int                             error_cnt = 0;
   int                             stall_cycles = 0;
   int                             gap_left = 0;
   bit                             calm = 1'b0;

   rate_monotonic_task_picker_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_ready_mask (req_ready_mask),
      .rsp_strobe     (rsp_strobe),
      .rsp_run_idle   (rsp_run_idle),
      .rsp_task_index (rsp_task_index),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic pick_type pick_task(input logic [rmtp_pkg::TASK_CNT-1:0] mask);
      pick_type res;
      logic     found;
      int       best;
      res.run_idle   = 1'b1;
      res.task_index = '0;
      found = 1'b0;
      best  = 0;
      if (mask == '0)
         return res;
      for (int t = 0; t < rmtp_pkg::TASK_CNT; t++) begin
         if (period_left[t] == '0) begin
            period_left[t] = period_cfg[t];
            budget_left[t] = budget_cfg[t];
         end
         if (period_left[t] != '0)
            period_left[t] = period_left[t] - rmtp_pkg::CNT_W'(1);
      end
      for (int t = 0; t < rmtp_pkg::TASK_CNT; t++) begin
         if (mask[t] && budget_left[t] != '0 && period_cfg[t] < rmtp_pkg::IDLE_PERIOD) begin
            if (!found || period_cfg[t] < period_cfg[best] ||
                (period_cfg[t] == period_cfg[best] && period_left[t] < period_left[best])) begin
               best  = t;
               found = 1'b1;
            end
         end
      end
      if (found) begin
         budget_left[best] = budget_left[best] - rmtp_pkg::CNT_W'(1);
         res.run_idle      = 1'b0;
         res.task_index    = best[rmtp_pkg::IDX_W-1:0];
      end
      return res;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         start          <= 1'b0;
         req_ready_mask <= '0;
         gap_left = 0;
      end else if (!start || !busy) begin
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
            start          <= 1'b0;
            req_ready_mask <= rmtp_pkg::TASK_CNT'($urandom_range(0, MASK_MAX));
         end else if (pending_ticks.size() > 0) begin
            start          <= 1'b1;
            req_ready_mask <= pending_ticks.pop_front();
            if (!calm && $urandom_range(0, 3) == 0)
               gap_left = $urandom_range(1, 4);
         end else begin
            start          <= 1'b0;
            req_ready_mask <= rmtp_pkg::TASK_CNT'($urandom_range(0, MASK_MAX));
         end
      end
   end

   // result monitor and prediction
   always @(posedge clock) begin
      pick_type want;
      if (reset) begin
         for (int t = 0; t < rmtp_pkg::TASK_CNT; t++) begin
            period_cfg[t]  = rmtp_pkg::PERIOD_RESET;
            budget_cfg[t]  = '0;
            period_left[t] = '0;
            budget_left[t] = '0;
         end
         expected_picks.delete();
      end else begin
         if (rsp_strobe) begin
            if (expected_picks.size() == 0) begin
               if (error_cnt < SHOWN_MISMATCHES)
                  $display("%0t: unexpected result run_idle %0b task_index %0d",
                           $realtime, rsp_run_idle, rsp_task_index);
               error_cnt++;
            end else begin
               want = expected_picks.pop_front();
               if (rsp_run_idle !== want.run_idle || rsp_task_index !== want.task_index) begin
                  if (error_cnt < SHOWN_MISMATCHES)
                     $display("%0t: mismatch run_idle exp %0b got %0b, task_index exp %0d got %0d",
                              $realtime, want.run_idle, rsp_run_idle,
                              want.task_index, rsp_task_index);
                  error_cnt++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index < CSR_BUDGET_BASE)
               period_cfg[csr_index[rmtp_pkg::IDX_W-1:0]] = csr_data;
            else if (csr_index < CSR_SPARE_FIRST)
               budget_cfg[csr_index[rmtp_pkg::IDX_W-1:0]] = csr_data;
         end
         if (start && !busy)
            expected_picks.push_back(pick_task(req_ready_mask));
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (start && !busy) || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic write_csr(input int idx, input logic [rmtp_pkg::CNT_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx[rmtp_pkg::CSR_IDX_W-1:0];
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // task zero sits in the low ten bits
   task automatic write_task_set(
      input logic [rmtp_pkg::TASK_CNT*rmtp_pkg::CNT_W-1:0] periods,
      input logic [rmtp_pkg::TASK_CNT*rmtp_pkg::CNT_W-1:0] budgets);
      for (int t = 0; t < rmtp_pkg::TASK_CNT; t++) begin
         write_csr(CSR_PERIOD_BASE + t, periods[t*rmtp_pkg::CNT_W +: rmtp_pkg::CNT_W]);
         write_csr(CSR_BUDGET_BASE + t, budgets[t*rmtp_pkg::CNT_W +: rmtp_pkg::CNT_W]);
      end
   endtask

   // first tick in the low nibble
   task automatic queue_ticks(input logic [63:0] masks, input int count);
      for (int n = 0; n < count; n++)
         pending_ticks.push_back(masks[n*rmtp_pkg::TASK_CNT +: rmtp_pkg::TASK_CNT]);
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_ticks.size() != 0 || start || expected_picks.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [rmtp_pkg::CNT_W-1:0] per;
      logic [rmtp_pkg::CNT_W-1:0] bud;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset values: zero budgets, so every tick picks idle
      queue_ticks(64'hA5F0, 4);
      wait_idle();

      // equal periods on tasks one and two, task three at the idle period
      write_task_set({10'd1000, 10'd3, 10'd3, 10'd2}, {10'd1023, 10'd2, 10'd2, 10'd1});
      write_csr(CSR_SPARE_FIRST + 1, 10'h3FF);
      queue_ticks(64'hF4201866FFFF, 12);
      wait_idle();

      // zero period, top period, zero budget
      write_task_set({10'd1, 10'd999, 10'd1023, 10'd0}, {10'd1, 10'd0, 10'd1023, 10'd1023});
      write_csr(CSR_SPARE_LAST, 10'h000);
      queue_ticks(64'hC384821F, 8);
      wait_idle();

      for (int p = 0; p < RAND_PHASES; p++) begin
         if (p == RAND_PHASES - 1)
            calm = 1'b1;
         for (int t = 0; t < rmtp_pkg::TASK_CNT; t++) begin
            case ($urandom_range(0, 9))
               0:       per = '0;
               1:       per = '1;
               2:       per = rmtp_pkg::IDLE_PERIOD;
               3:       per = rmtp_pkg::IDLE_PERIOD - rmtp_pkg::CNT_W'(1);
               default: per = rmtp_pkg::CNT_W'($urandom_range(1, 12));
            endcase
            case ($urandom_range(0, 9))
               0:       bud = '0;
               1:       bud = '1;
               default: bud = rmtp_pkg::CNT_W'($urandom_range(1, 6));
            endcase
            write_csr(CSR_PERIOD_BASE + t, per);
            write_csr(CSR_BUDGET_BASE + t, bud);
         end
         write_csr($urandom_range(CSR_SPARE_FIRST, CSR_SPARE_LAST),
                   rmtp_pkg::CNT_W'($urandom_range(0, (1 << rmtp_pkg::CNT_W) - 1)));
         for (int n = 0; n < PHASE_TICKS; n++) begin
            if ($urandom_range(0, 9) == 0)
               pending_ticks.push_back('0);
            else
               pending_ticks.push_back(rmtp_pkg::TASK_CNT'($urandom_range(1, MASK_MAX)));
         end
         wait_idle();
      end

      if (error_cnt == 0 && expected_picks.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/rmtp_pkg.sv
hw/rtl/rmtp_cell.sv
hw/rtl/rate_monotonic_task_picker_unit.sv
tb/testbench.sv
